[rtl/mbh_pkg.sv]
// ----------------------------------------------------------------------------
// mbh_pkg: shared definitions for the multichannel biquad high-pass block
// Widths, register indexes, microcode word layout, the control program and
// a saturation helper.
// ----------------------------------------------------------------------------
package mbh_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_CFG_W    = 4;
  localparam int CNT_W        = ($clog2(MAX_CHANNELS + 1) > CNT_CFG_W) ?
                                $clog2(MAX_CHANNELS + 1) : CNT_CFG_W;

  localparam int SMP_W  = 24;  // Q1.23 samples
  localparam int COEF_W = 32;  // Q2.30 coefficients
  localparam int ST_W   = 40;  // Q8.32 delay words
  localparam int YQ_W   = 32;  // Q8.24 feedback operand
  localparam int PROD_W = 64;
  localparam int ACC_W  = 44;  // holds any exact sum of Q.32 terms
  localparam int IDX_W  = 3;
  localparam int OUT_CH_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_COEF_B0       = 3'd1,
    REG_COEF_B1       = 3'd2,
    REG_COEF_B2       = 3'd3,
    REG_COEF_A1       = 3'd4,
    REG_COEF_A2       = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,  // advance unconditionally
    COND_WAIT_IN  = 2'd1,  // hold until a sample transaction
    COND_WAIT_OUT = 2'd2   // hold while the output register is full, then return
  } cond_e;

  typedef struct packed {
    coef_sel_e coef_sel;
    logic      opnd_yq;
    logic      mul_en;
    logic      ld_y;
    logic      ld_acc;
    logic      ld_yq;
    logic      ld_acc2;
    logic      wr_fd;
    logic      wr_sd;
    logic      emit;
    cond_e     cond;
  } uword_t;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL0 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  // Control program, one word per step.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{coef_sel: COEF_B0, opnd_yq: 1'b0, mul_en: 1'b0, ld_y: 1'b0,
          ld_acc: 1'b0, ld_yq: 1'b0, ld_acc2: 1'b0, wr_fd: 1'b0,
          wr_sd: 1'b0, emit: 1'b0, cond: COND_NEXT};
    case (step)
      3'd0: begin
        w.cond = COND_WAIT_IN;
      end
      3'd1: begin
        w.coef_sel = COEF_B0; w.mul_en = 1'b1;
      end
      3'd2: begin
        w.ld_y = 1'b1; w.coef_sel = COEF_B1; w.mul_en = 1'b1;
      end
      3'd3: begin
        w.ld_acc = 1'b1; w.ld_yq = 1'b1; w.coef_sel = COEF_B2; w.mul_en = 1'b1;
      end
      3'd4: begin
        w.ld_acc2 = 1'b1; w.coef_sel = COEF_A1; w.opnd_yq = 1'b1; w.mul_en = 1'b1;
      end
      3'd5: begin
        w.wr_fd = 1'b1; w.coef_sel = COEF_A2; w.opnd_yq = 1'b1; w.mul_en = 1'b1;
      end
      3'd6: begin
        w.wr_sd = 1'b1; w.emit = 1'b1; w.cond = COND_WAIT_OUT;
      end
      default: begin
        w.cond = COND_WAIT_OUT;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > ACC_W'($signed({1'b0, {(ST_W-1){1'b1}}}))) begin
      r = {1'b0, {(ST_W-1){1'b1}}};
    end else if (v < ACC_W'($signed({1'b1, {(ST_W-1){1'b0}}}))) begin
      r = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/multichannel_biquad_highpass.sv]
// ----------------------------------------------------------------------------
// multichannel_biquad_highpass: interleaved multichannel biquad filter
// Transposed direct form II section per channel, fixed point, driven by a
// small microcode program over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one channel after the other; tuser
//   carries the command bit (0 filter, 1 clear all state and channel position).
//   A clear completes in the cycle it is accepted and produces no result.
//   Results leave on the m_axis channel with the channel index in tdata and
//   tlast set on the last channel of a frame.
//   Coefficients and the channel count are written through the cfg channel,
//   which is always ready; write it only while no sample is in flight.
// Timing:
//   A sample runs through six program steps from acceptance until its result
//   is loaded into the output register, set by the five passes through the
//   shared multiplier plus the final write-back step. The sequencer then
//   returns to its idle step, and no new sample is accepted before it does.
//   The input accepts the next item while a result waits.
// Reset and stall:
//   Reset zeroes all delay words and the position, and loads default
//   coefficients (b0 = 1.0). If the receiver stalls, the last program step
//   holds until the output register empties; nothing is dropped.
// ----------------------------------------------------------------------------
module multichannel_biquad_highpass (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [23:0] sample_out, [26:24] channel_index
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int CH_W  = mbh_pkg::CH_W;
  localparam int CNT_W = mbh_pkg::CNT_W;
  localparam int ACC_W = mbh_pkg::ACC_W;
  localparam int ST_W  = mbh_pkg::ST_W;

  // configuration registers
  logic [mbh_pkg::CNT_CFG_W-1:0]       cnt_q;
  logic signed [mbh_pkg::COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;

  // channel state
  logic signed [ST_W-1:0] fd_q [mbh_pkg::MAX_CHANNELS];
  logic signed [ST_W-1:0] sd_q [mbh_pkg::MAX_CHANNELS];
  logic [CH_W-1:0]        pos_q, pos_d;

  // sequencer and datapath registers
  logic [mbh_pkg::STEP_W-1:0]          step_q, step_d;
  logic [CH_W-1:0]                     ch_q;
  logic                                last_q;
  logic signed [mbh_pkg::SMP_W-1:0]    x_q;
  logic signed [mbh_pkg::PROD_W-1:0]   prod_q;
  logic signed [ST_W-1:0]              y_q;
  logic signed [mbh_pkg::YQ_W-1:0]     yq_q;
  logic signed [ACC_W-1:0]             acc_q, acc2_q;

  logic                                out_valid_q;
  logic signed [mbh_pkg::SMP_W-1:0]    out_smp_q;
  logic [mbh_pkg::OUT_CH_W-1:0]        out_ch_q;
  logic                                out_last_q;

  mbh_pkg::uword_t uw;
  logic s_acc, smp_acc, clr_acc, out_free, go;

  assign uw            = mbh_pkg::ucode(step_q);
  assign s_axis_tready = (step_q == mbh_pkg::STEP_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign smp_acc       = s_acc && !s_axis_tuser;
  assign clr_acc       = s_acc && s_axis_tuser;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign go            = (uw.cond != mbh_pkg::COND_WAIT_OUT) || out_free;
  assign cfg_ready_o   = 1'b1;

  // ---------------- channel selection ----------------
  logic [CNT_W-1:0] cnt_ext, cnt_eff, c_plus1;
  logic [CH_W-1:0]  c_sel;
  logic             frame_end;

  always_comb begin
    cnt_ext = CNT_W'(cnt_q);
    if (cnt_ext == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_ext > CNT_W'(mbh_pkg::MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(mbh_pkg::MAX_CHANNELS);
    end else begin
      cnt_eff = cnt_ext;
    end
    // wrap a stale position left behind by a lowered count
    c_sel     = (CNT_W'(pos_q) >= cnt_eff) ? '0 : pos_q;
    c_plus1   = CNT_W'(c_sel) + CNT_W'(1);
    frame_end = (c_plus1 == cnt_eff);
    pos_d     = (c_plus1 >= cnt_eff) ? '0 : c_plus1[CH_W-1:0];
  end

  // ---------------- step counter ----------------
  always_comb begin
    step_d = step_q;
    case (uw.cond)
      mbh_pkg::COND_WAIT_IN: begin
        if (smp_acc) step_d = mbh_pkg::STEP_MUL0;
      end
      mbh_pkg::COND_WAIT_OUT: begin
        if (out_free) step_d = mbh_pkg::STEP_IDLE;
      end
      default: begin
        step_d = step_q + mbh_pkg::STEP_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mbh_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= mbh_pkg::CNT_CFG_W'(1);
      b0_q  <= 32'sd1073741824;
      b1_q  <= '0;
      b2_q  <= '0;
      a1_q  <= '0;
      a2_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mbh_pkg::REG_CHANNEL_COUNT: cnt_q <= cfg_data_i[mbh_pkg::CNT_CFG_W-1:0];
        mbh_pkg::REG_COEF_B0:       b0_q  <= cfg_data_i;
        mbh_pkg::REG_COEF_B1:       b1_q  <= cfg_data_i;
        mbh_pkg::REG_COEF_B2:       b2_q  <= cfg_data_i;
        mbh_pkg::REG_COEF_A1:       a1_q  <= cfg_data_i;
        mbh_pkg::REG_COEF_A2:       a2_q  <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------- datapath ----------------
  logic signed [mbh_pkg::COEF_W-1:0] coef_m, opnd_m;
  logic signed [mbh_pkg::PROD_W-1:0] ff_sum, fb_sum;
  logic signed [ACC_W-1:0]           ff_t, fb_t, y_sum;
  logic signed [ST_W:0]              yq_rnd, out_rnd;
  logic signed [mbh_pkg::YQ_W:0]     yq_sh;
  logic signed [mbh_pkg::YQ_W-1:0]   yq_d;
  logic signed [ST_W-9:0]            out_sh;
  logic signed [mbh_pkg::SMP_W-1:0]  out_d;
  logic signed [ST_W-1:0]            fd_cur, sd_cur;

  assign fd_cur = fd_q[ch_q];
  assign sd_cur = sd_q[ch_q];

  always_comb begin
    case (uw.coef_sel)
      mbh_pkg::COEF_B0: coef_m = b0_q;
      mbh_pkg::COEF_B1: coef_m = b1_q;
      mbh_pkg::COEF_B2: coef_m = b2_q;
      mbh_pkg::COEF_A1: coef_m = a1_q;
      mbh_pkg::COEF_A2: coef_m = a2_q;
      default:          coef_m = b0_q;
    endcase
    opnd_m = uw.opnd_yq ? yq_q : mbh_pkg::COEF_W'(x_q);

    // round Q.53 and Q.54 products to Q.32
    ff_sum = prod_q + mbh_pkg::PROD_W'(64'sd1048576);
    fb_sum = prod_q + mbh_pkg::PROD_W'(64'sd2097152);
    ff_t   = ACC_W'($signed(ff_sum[mbh_pkg::PROD_W-1:21]));
    fb_t   = ACC_W'($signed(fb_sum[mbh_pkg::PROD_W-1:22]));
    y_sum  = ff_t + ACC_W'(fd_cur);

    yq_rnd = (ST_W+1)'(y_q) + (ST_W+1)'(41'sd128);
    yq_sh  = yq_rnd[ST_W:8];
    if (yq_sh > 33'sh0_7FFF_FFFF) begin
      yq_d = 32'sh7FFF_FFFF;
    end else if (yq_sh < -33'sh0_8000_0000) begin
      yq_d = -32'sh8000_0000;
    end else begin
      yq_d = yq_sh[mbh_pkg::YQ_W-1:0];
    end

    out_rnd = (ST_W+1)'(y_q) + (ST_W+1)'(41'sd256);
    out_sh  = out_rnd[ST_W:9];
    if (out_sh > 32'sd8388607) begin
      out_d = 24'sh7F_FFFF;
    end else if (out_sh < -32'sd8388608) begin
      out_d = -24'sh80_0000;
    end else begin
      out_d = out_sh[mbh_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      x_q    <= s_axis_tdata;
      ch_q   <= c_sel;
      last_q <= frame_end;
    end
    if (uw.mul_en)  prod_q <= coef_m * opnd_m;
    if (uw.ld_y)    y_q    <= mbh_pkg::sat_st(y_sum);
    if (uw.ld_acc)  acc_q  <= ff_t + ACC_W'(sd_cur);
    if (uw.ld_yq)   yq_q   <= yq_d;
    if (uw.ld_acc2) acc2_q <= ff_t;
    if (uw.emit && go) begin
      out_smp_q  <= out_d;
      out_ch_q   <= mbh_pkg::OUT_CH_W'(ch_q);
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < mbh_pkg::MAX_CHANNELS; i++) begin
        fd_q[i] <= '0;
        sd_q[i] <= '0;
      end
    end else begin
      if (clr_acc) begin
        pos_q <= '0;
        for (int i = 0; i < mbh_pkg::MAX_CHANNELS; i++) begin
          fd_q[i] <= '0;
          sd_q[i] <= '0;
        end
      end else begin
        if (smp_acc)           pos_q      <= pos_d;
        if (uw.wr_fd)          fd_q[ch_q] <= mbh_pkg::sat_st(acc_q - fb_t);
        if (uw.wr_sd && go)    sd_q[ch_q] <= mbh_pkg::sat_st(acc2_q - fb_t);
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.emit && go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_ch_q, out_smp_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> step_q == mbh_pkg::STEP_MUL0)
    else $error("sequencer did not start after a sample transaction");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_acc |=> (pos_q == '0) && (step_q == mbh_pkg::STEP_IDLE))
    else $error("clear left a channel position or started the program");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> CNT_W'(pos_q) < $past(cnt_eff))
    else $error("channel position past the channel count");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == mbh_pkg::STEP_LAST && out_free) |=>
      m_axis_tvalid && step_q == mbh_pkg::STEP_IDLE)
    else $error("result not loaded at the end of the program");

endmodule
